[sv/ddt_pkg.sv]
// ----------------------------------------------------------------------------
// Dual debounced tachometer package
// Shared constants, item kind codes and lane control type.
// ----------------------------------------------------------------------------
package ddt_pkg;

    // Debounce depth: stable high samples needed after a low one.
    localparam int STABLE_SAMPLES = 12;

    // Item kind codes.
    localparam logic [1:0] KIND_TICK      = 2'd0;
    localparam logic [1:0] KIND_CLR_LEFT  = 2'd1;
    localparam logic [1:0] KIND_CLR_RIGHT = 2'd2;

    // Register indexes on the configuration port.
    localparam logic REG_HOLES    = 1'b0;
    localparam logic REG_INTERVAL = 1'b1;

    // Register reset values.
    localparam logic [7:0]  HOLES_RESET    = 8'd20;
    localparam logic [15:0] INTERVAL_RESET = 16'd1000;

    // Milliseconds per minute, the dividend of the scale computation.
    localparam int MS_PER_MINUTE = 60 * 1000;

    // Width of the shared divider and of the scale factor.
    localparam int DIV_BITS = 16;

    // Scale that matches the register reset values, worked out at elaboration.
    localparam logic [DIV_BITS-1:0] SCALE_RESET =
        DIV_BITS'((MS_PER_MINUTE / int'(HOLES_RESET)) / int'(INTERVAL_RESET));

    // Per-lane control for one accepted item.
    typedef struct packed {
        logic tick;    // tick item accepted
        logic clear;   // clear item for this lane accepted
        logic survey;  // survey deadline passed on this tick
    } t_lane_ctl;

endpackage

[sv/ddt_in_if.sv]
// ----------------------------------------------------------------------------
// Tachometer input channel
// Valid/ready channel carrying one tick or clear word.
// ----------------------------------------------------------------------------
interface ddt_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic        left_sample;
    logic        right_sample;
    logic [31:0] now_ms;

    modport source (output valid, kind, left_sample, right_sample, now_ms, input ready);
    modport sink   (input valid, kind, left_sample, right_sample, now_ms, output ready);
endinterface

[sv/ddt_out_if.sv]
// ----------------------------------------------------------------------------
// Tachometer result channel
// Valid/ready channel carrying both speeds and both step totals.
// ----------------------------------------------------------------------------
interface ddt_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] left_rpm;
    logic [15:0] right_rpm;
    logic [31:0] left_steps;
    logic [31:0] right_steps;

    modport source (output valid, left_rpm, right_rpm, left_steps, right_steps, input ready);
    modport sink   (input valid, left_rpm, right_rpm, left_steps, right_steps, output ready);
endinterface

[sv/ddt_lane.sv]
// ----------------------------------------------------------------------------
// Tachometer lane
// Debounce history, interval counter, step total and speed of one sensor.
// ----------------------------------------------------------------------------
module ddt_lane #(
    parameter int STABLE_SAMPLES = ddt_pkg::STABLE_SAMPLES
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ddt_pkg::t_lane_ctl           i_ctl,
    input  logic                         i_sample,
    input  logic [ddt_pkg::DIV_BITS-1:0] i_scale,
    output logic [15:0]                  o_speed_next,
    output logic [31:0]                  o_steps_next
);

    // History bits forced high above the stable window, and the pulse pattern.
    localparam logic [15:0] HIST_FORCED = 16'(16'hffff << (STABLE_SAMPLES + 1));
    localparam logic [15:0] HIST_PULSE  = HIST_FORCED | 16'(16'h1 << STABLE_SAMPLES);

    logic [15:0] r_history, n_history;
    logic [15:0] r_count,   n_count;
    logic [31:0] r_steps,   n_steps;
    logic [15:0] r_speed,   n_speed;

    logic [31:0] product;
    logic [15:0] speed_sat;
    logic [15:0] count_base;
    logic        pulse;

    // Speed from the interval count, saturated to 16 bits.
    assign product   = 32'(i_scale) * 32'(r_count);
    assign speed_sat = (|product[31:16]) ? 16'hffff : product[15:0];

    // Next state: survey first, then debounce and count; a clear zeroes the interval count and step total.
    always_comb begin
        n_history = r_history;
        n_count   = r_count;
        n_steps   = r_steps;
        n_speed   = r_speed;
        count_base = i_ctl.survey ? 16'd0 : r_count;
        pulse = 1'b0;
        if (i_ctl.tick) begin
            if (i_ctl.survey) begin
                n_speed = speed_sat;
            end
            n_history = {r_history[14:0], ~i_sample} | HIST_FORCED;
            pulse     = (n_history == HIST_PULSE);
            n_count   = count_base;
            if (pulse) begin
                if (count_base != 16'hffff) begin
                    n_count = count_base + 16'd1;
                end
                n_steps = r_steps + 32'd1;
            end
        end else if (i_ctl.clear) begin
            n_count = 16'd0;
            n_steps = 32'd0;
        end
    end

    // Lane state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_history <= '0;
            r_count   <= '0;
            r_steps   <= '0;
            r_speed   <= '0;
        end else begin
            r_history <= n_history;
            r_count   <= n_count;
            r_steps   <= n_steps;
            r_speed   <= n_speed;
        end
    end

    assign o_speed_next = n_speed;
    assign o_steps_next = n_steps;

endmodule

[sv/ddt_scale_div.sv]
// ----------------------------------------------------------------------------
// Tachometer scale divider
// Restoring divider, one quotient bit per cycle, run twice to form
// (minute / holes) / interval.
// ----------------------------------------------------------------------------
module ddt_scale_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [7:0]                   i_holes,
    input  logic [15:0]                  i_interval,
    output logic [ddt_pkg::DIV_BITS-1:0] o_scale,
    output logic                         o_busy
);

    localparam int W  = ddt_pkg::DIV_BITS;
    localparam int CW = $clog2(W);
    localparam logic [CW-1:0] LAST_STEP = CW'(W - 1);
    localparam logic [W-1:0]  DIVIDEND  = W'(ddt_pkg::MS_PER_MINUTE);

    typedef enum logic [1:0] {S_IDLE, S_PASS1, S_PASS2} t_state;

    t_state        r_state;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_quo;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_scale;

    logic [W-1:0]  divisor;
    logic [W:0]    trial;
    logic          fits;
    logic [W-1:0]  n_rem;
    logic [W-1:0]  n_quo;

    // One restoring step on the current pass.
    always_comb begin
        divisor = (r_state == S_PASS1) ? W'(i_holes) : W'(i_interval);
        trial   = {r_rem, r_quo[W-1]};
        fits    = (trial >= {1'b0, divisor});
        n_rem   = fits ? W'(trial - {1'b0, divisor}) : trial[W-1:0];
        n_quo   = {r_quo[W-2:0], fits};
    end

    // Sequencer and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_scale <= ddt_pkg::SCALE_RESET;
        end else if (i_start) begin
            r_cnt <= '0;
            r_rem <= '0;
            r_quo <= DIVIDEND;
            if (i_holes == 8'd0 || i_interval == 16'd0) begin
                r_scale <= '0;
                r_state <= S_IDLE;
            end else begin
                r_state <= S_PASS1;
            end
        end else begin
            case (r_state)
                S_PASS1: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == LAST_STEP) begin
                        r_state <= S_PASS2;
                        r_rem   <= '0;
                        r_quo   <= n_quo;
                    end else begin
                        r_rem <= n_rem;
                        r_quo <= n_quo;
                    end
                end
                S_PASS2: begin
                    r_cnt <= r_cnt + 1'b1;
                    r_rem <= n_rem;
                    r_quo <= n_quo;
                    if (r_cnt == LAST_STEP) begin
                        r_scale <= n_quo;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_scale = r_scale;
    assign o_busy  = (r_state != S_IDLE);

endmodule

[sv/dual_debounced_tachometer_unit.sv]
// ----------------------------------------------------------------------------
// Dual debounced tachometer
// Two optical sensor lanes with debouncing, step totals and periodic speed.
// ----------------------------------------------------------------------------
// Usage:
// Input words arrive on i_in: a tick carries both raw pin samples and the
// millisecond time, a clear word zeroes one side's step total and interval
// count. Every accepted word yields one result word on o_out with both
// speeds (rpm, saturated) and both step totals after that word's update.
// Throughput is one word per cycle while the divider is idle; the result
// is registered in the cycle after acceptance. The output register is
// loaded whenever it is empty or being taken, so a stalled receiver holds
// the input off only while a result is still waiting.
// The APB port holds encoder_holes (byte address 0) and survey_interval_ms
// (byte address 4). A write restarts the scale divider, which, after a
// registered start, forms one quotient bit per cycle over two passes;
// i_in.ready stays low until it finishes.
// Reset clears all lane state, disarms the survey deadline and loads the
// scale that matches the register reset values, so words are taken at once.
// ----------------------------------------------------------------------------
module dual_debounced_tachometer_unit #(
    parameter int STABLE_SAMPLES = ddt_pkg::STABLE_SAMPLES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ddt_in_if.sink      i_in,
    ddt_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]  r_holes;
    logic [15:0] r_interval;
    logic        r_div_start;
    logic [31:0] r_deadline, n_deadline;
    logic        r_armed,    n_armed;

    logic        r_out_valid;
    logic [15:0] r_left_rpm, r_right_rpm;
    logic [31:0] r_left_steps, r_right_steps;

    logic                         cfg_wr;
    logic [ddt_pkg::DIV_BITS-1:0] scale;
    logic                         div_busy;
    logic                         accept;
    logic                         acc_tick;
    logic                         survey;
    logic [31:0]                  elapsed;
    ddt_pkg::t_lane_ctl           left_ctl, right_ctl;
    logic [15:0]                  left_speed_next, right_speed_next;
    logic [31:0]                  left_steps_next, right_steps_next;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == ddt_pkg::REG_INTERVAL) ? {16'd0, r_interval}
                                                        : {24'd0, r_holes};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_holes     <= ddt_pkg::HOLES_RESET;
            r_interval  <= ddt_pkg::INTERVAL_RESET;
            r_div_start <= 1'b0;
        end else begin
            r_div_start <= cfg_wr;
            if (cfg_wr) begin
                if (paddr[2] == ddt_pkg::REG_HOLES) begin
                    r_holes <= pwdata[7:0];
                end else begin
                    r_interval <= pwdata[15:0];
                end
            end
        end
    end

    // Scale factor divider.
    ddt_scale_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_holes    (r_holes),
        .i_interval (r_interval),
        .o_scale    (scale),
        .o_busy     (div_busy)
    );

    // Input handshake: blocked while the scale is being recomputed or a result waits.
    assign i_in.ready = !div_busy && !r_div_start && (!r_out_valid || o_out.ready);
    assign accept     = i_in.valid && i_in.ready;
    assign acc_tick   = accept && (i_in.kind == ddt_pkg::KIND_TICK);

    // Survey deadline; passed means the wrapped difference is small and positive.
    assign elapsed = i_in.now_ms - r_deadline;
    always_comb begin
        n_deadline = r_deadline;
        n_armed    = r_armed;
        survey     = 1'b0;
        if (acc_tick) begin
            if (!r_armed) begin
                n_deadline = i_in.now_ms + 32'(r_interval);
                n_armed    = 1'b1;
            end else if (elapsed != 32'd0 && !elapsed[31]) begin
                survey     = 1'b1;
                n_deadline = i_in.now_ms + 32'(r_interval);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadline <= '0;
            r_armed    <= 1'b0;
        end else begin
            r_deadline <= n_deadline;
            r_armed    <= n_armed;
        end
    end

    // Lane controls.
    always_comb begin
        left_ctl.tick    = acc_tick;
        left_ctl.survey  = survey;
        left_ctl.clear   = accept && (i_in.kind == ddt_pkg::KIND_CLR_LEFT);
        right_ctl.tick   = acc_tick;
        right_ctl.survey = survey;
        right_ctl.clear  = accept && (i_in.kind == ddt_pkg::KIND_CLR_RIGHT);
    end

    ddt_lane #(.STABLE_SAMPLES(STABLE_SAMPLES)) u_left (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (left_ctl),
        .i_sample     (i_in.left_sample),
        .i_scale      (scale),
        .o_speed_next (left_speed_next),
        .o_steps_next (left_steps_next)
    );

    ddt_lane #(.STABLE_SAMPLES(STABLE_SAMPLES)) u_right (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (right_ctl),
        .i_sample     (i_in.right_sample),
        .i_scale      (scale),
        .o_speed_next (right_speed_next),
        .o_steps_next (right_steps_next)
    );

    // Output register merging both lanes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_left_rpm    <= left_speed_next;
            r_right_rpm   <= right_speed_next;
            r_left_steps  <= left_steps_next;
            r_right_steps <= right_steps_next;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.left_rpm    = r_left_rpm;
    assign o_out.right_rpm   = r_right_rpm;
    assign o_out.left_steps  = r_left_steps;
    assign o_out.right_steps = r_right_steps;

    // Assertions.
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_out.valid)
        else $error("accepted word produced no result");

    a_first_tick_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_tick && !r_armed) |=> r_armed)
        else $error("first tick did not arm the deadline");

    a_clear_left_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.kind == ddt_pkg::KIND_CLR_LEFT) |=> (o_out.left_steps == 32'd0))
        else $error("left clear did not zero the step total");

    a_cfg_stalls_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> ##1 (div_busy || scale == '0))
        else $error("configuration write did not restart the divider");

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// Dual debounced tachometer testbench
// Drives tick, clear and reserved words through the input channel and
// register writes through the APB port, predicts every result word from a
// local model of the debounce, step counting and survey logic, and compares
// each result word field by field with the oldest prediction.
// ----------------------------------------------------------------------------

// Predicts the tachometer state and holds the result words still to come.
class tach_scoreboard;

    typedef struct packed {
        logic [15:0] left_rpm;
        logic [15:0] right_rpm;
        logic [31:0] left_steps;
        logic [31:0] right_steps;
    } t_reading;

    // Forced top bits of each history and the value that marks a clean pulse.
    localparam logic [15:0] HIST_FORCED = 16'(16'hffff << (ddt_pkg::STABLE_SAMPLES + 1));
    localparam logic [15:0] HIST_PULSE  = HIST_FORCED | 16'(1 << ddt_pkg::STABLE_SAMPLES);

    logic [7:0]  holes;
    logic [15:0] interval;
    int unsigned scale;

    logic [15:0] history[2];
    logic [15:0] interval_count[2];
    logic [31:0] step_total[2];
    logic [15:0] rpm[2];
    logic [31:0] deadline;
    bit          armed;

    t_reading    expected_readings[$];
    int unsigned errors;
    int unsigned words, pulses, surveys, clears;

    function new();
        holes    = ddt_pkg::HOLES_RESET;
        interval = ddt_pkg::INTERVAL_RESET;
        rescale();
        for (int side = 0; side < 2; side++) begin
            history[side]        = '0;
            interval_count[side] = '0;
            step_total[side]     = '0;
            rpm[side]            = '0;
        end
        deadline = '0;
        armed    = 1'b0;
        errors   = 0;
        words    = 0;
        pulses   = 0;
        surveys  = 0;
        clears   = 0;
    endfunction

    // The scale is the whole rpm per pulse counted in one survey interval.
    function void rescale();
        if (holes == 0 || interval == 0) begin
            scale = 0;
        end else begin
            scale = (ddt_pkg::MS_PER_MINUTE / holes) / interval;
        end
    endfunction

    function logic [15:0] rpm_of(logic [15:0] count);
        logic [47:0] product;
        product = scale * count;
        return (product > 48'd65535) ? 16'hffff : product[15:0];
    endfunction

    function void write_register(logic idx, logic [31:0] value);
        if (idx == ddt_pkg::REG_HOLES) begin
            holes = value[7:0];
        end else begin
            interval = value[15:0];
        end
        rescale();
    endfunction

    function logic [31:0] register_value(logic idx);
        return (idx == ddt_pkg::REG_HOLES) ? {24'b0, holes} : {16'b0, interval};
    endfunction

    function void report_mismatch(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            errors++;
            $error("%s: expected %0d, actual %0d", field, want, got);
        end
    endfunction

    // Applies one accepted word and queues the result word it must produce.
    function void note_word(logic [1:0] kind, logic left_s, logic right_s, logic [31:0] now);
        t_reading    reading;
        logic [31:0] lag;
        logic [1:0]  samples;
        samples = {right_s, left_s};
        words++;
        if (kind == ddt_pkg::KIND_TICK) begin
            if (!armed) begin
                // The first tick arms the survey deadline without a survey.
                deadline = now + 32'(interval);
                armed    = 1'b1;
            end else begin
                // Passed means the wrapped distance lies in the lower half.
                lag = now - deadline;
                if (lag != 0 && !lag[31]) begin
                    for (int side = 0; side < 2; side++) begin
                        rpm[side]            = rpm_of(interval_count[side]);
                        interval_count[side] = '0;
                    end
                    deadline = now + 32'(interval);
                    surveys++;
                end
            end
            for (int side = 0; side < 2; side++) begin
                history[side] = (history[side] << 1) | {15'b0, ~samples[side]} | HIST_FORCED;
                if (history[side] == HIST_PULSE) begin
                    if (interval_count[side] != 16'hffff) interval_count[side]++;
                    step_total[side]++;
                    pulses++;
                end
            end
        end else if (kind == ddt_pkg::KIND_CLR_LEFT || kind == ddt_pkg::KIND_CLR_RIGHT) begin
            int side;
            side = (kind == ddt_pkg::KIND_CLR_LEFT) ? 0 : 1;
            step_total[side]     = '0;
            interval_count[side] = '0;
            clears++;
        end
        reading.left_rpm    = rpm[0];
        reading.right_rpm   = rpm[1];
        reading.left_steps  = step_total[0];
        reading.right_steps = step_total[1];
        expected_readings.push_back(reading);
    endfunction

    function void check_reading(logic [15:0] left_rpm, logic [15:0] right_rpm,
                                logic [31:0] left_steps, logic [31:0] right_steps);
        t_reading want;
        if (expected_readings.size() == 0) begin
            errors++;
            $error("result word arrived with no word outstanding");
            return;
        end
        want = expected_readings.pop_front();
        report_mismatch("left_rpm", {16'b0, want.left_rpm}, {16'b0, left_rpm});
        report_mismatch("right_rpm", {16'b0, want.right_rpm}, {16'b0, right_rpm});
        report_mismatch("left_steps", want.left_steps, left_steps);
        report_mismatch("right_steps", want.right_steps, right_steps);
    endfunction

    function int outstanding();
        return expected_readings.size();
    endfunction

endclass

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Reserved kind: the block must leave its state alone but still report.
    localparam logic [1:0]  KIND_NONE   = 2'd3;
    localparam int unsigned QUIET_LIMIT = 2000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ddt_in_if  in_if();
    ddt_out_if out_if();

    dual_debounced_tachometer_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    tach_scoreboard sb = new();

    // Idling controls, rerolled in stretches so that quiet spans occur too.
    bit          idling_allowed = 1'b1;
    bit          gaps_on        = 1'b1;
    bit          stalls_on      = 1'b1;
    int          stall_count    = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned settings       = 1;

    // Pulse train generators for the two sensors, plus the running time.
    logic [1:0]  level      = 2'b00;
    int          run_left[2] = '{0, 0};
    logic [31:0] now_cursor = '0;

    always #6 i_clk = ~i_clk;

    // Receiver: check each accepted result word, then stall in random bursts.
    always @(posedge i_clk) begin
        if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            sb.check_reading(out_if.left_rpm, out_if.right_rpm,
                             out_if.left_steps, out_if.right_steps);
        end
        if (stall_count > 0) begin
            stall_count--;
            out_if.ready <= 1'b0;
        end else if (stalls_on && $urandom_range(0, 5) == 0) begin
            stall_count = $urandom_range(0, 6);
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    // Watchdog: ends the run when nothing moves on any port for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
                || (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one word, after an optional gap, and waits for it to be taken.
    task automatic send_word(input logic [1:0] kind, input logic left_s,
                             input logic right_s, input logic [31:0] now);
        int gap;
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 7);
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.kind         <= kind;
        in_if.left_sample  <= left_s;
        in_if.right_sample <= right_s;
        in_if.now_ms       <= now;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        sb.note_word(kind, left_s, right_s, now);
    endtask

    // Holds the sender off until every predicted result word has come back.
    task automatic wait_for_readings();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (sb.outstanding() != 0);
    endtask

    // APB write of one register followed by a read back of its value.
    task automatic write_register(input logic idx, input logic [31:0] value);
        logic [31:0] stored;
        string       field;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        sb.write_register(idx, value);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        stored = sb.register_value(idx);
        if (idx == ddt_pkg::REG_HOLES) begin
            field = "encoder_holes readback";
        end else begin
            field = "survey_interval_ms readback";
        end
        sb.report_mismatch(field, stored, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Next pin level of one sensor: high runs around the debounce length, short
    // low runs, and an occasional one-sample glitch.
    function automatic logic next_level(int side);
        if (run_left[side] == 0) begin
            level[side]    = ~level[side];
            run_left[side] = level[side] ? $urandom_range(9, 16) : $urandom_range(1, 4);
        end
        run_left[side]--;
        if ($urandom_range(0, 29) == 0) return ~level[side];
        return level[side];
    endfunction

    task automatic random_words(input int count, input int unsigned step_max);
        int roll;
        for (int n = 0; n < count; n++) begin
            if (n % 32 == 0) begin
                gaps_on   = idling_allowed && $urandom_range(0, 2) != 0;
                stalls_on = idling_allowed && $urandom_range(0, 2) != 0;
            end
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                send_word(ddt_pkg::KIND_CLR_LEFT, 1'($urandom), 1'($urandom), $urandom);
            end else if (roll < 6) begin
                send_word(ddt_pkg::KIND_CLR_RIGHT, 1'($urandom), 1'($urandom), $urandom);
            end else if (roll < 7) begin
                send_word(KIND_NONE, 1'($urandom), 1'($urandom), $urandom);
            end else begin
                // Mostly small steps forward, now and then a long jump or a
                // step back in time.
                roll = $urandom_range(0, 99);
                if (roll < 2) begin
                    now_cursor += $urandom_range(1, 32'h7fff_0000);
                end else if (roll < 5) begin
                    now_cursor -= $urandom_range(1, 4 * step_max);
                end else begin
                    now_cursor += $urandom_range(0, step_max);
                end
                send_word(ddt_pkg::KIND_TICK, next_level(0), next_level(1), now_cursor);
            end
            if (idling_allowed && $urandom_range(0, 149) == 0) wait_for_readings();
        end
    endtask

    // One setting of both registers, written while the block is idle.
    task automatic run_phase(input logic [7:0] holes, input logic [15:0] interval,
                             input int count);
        wait_for_readings();
        write_register(ddt_pkg::REG_HOLES, {24'b0, holes});
        write_register(ddt_pkg::REG_INTERVAL, {16'b0, interval});
        settings++;
        random_words(count, interval / 16 + 1);
    endtask

    // Directed words: reserved kind and clears before arming, arming across
    // the time wrap, one pulse per side, and the deadline boundaries.
    task automatic directed_words();
        logic [31:0] start;
        logic [31:0] mark;
        start = 32'hffff_fff0;
        mark  = start + 32'(ddt_pkg::INTERVAL_RESET);
        send_word(KIND_NONE, 1'b1, 1'b1, 32'hffff_ffff);
        send_word(ddt_pkg::KIND_CLR_LEFT, 1'b1, 1'b0, 32'h0000_0000);
        send_word(ddt_pkg::KIND_CLR_RIGHT, 1'b0, 1'b1, 32'hffff_ffff);
        send_word(ddt_pkg::KIND_TICK, 1'b0, 1'b0, start);
        for (int i = 0; i < 13; i++) begin
            send_word(ddt_pkg::KIND_TICK, 1'(i < 12), 1'(i > 0), start + i);
        end
        send_word(ddt_pkg::KIND_TICK, 1'b1, 1'b1, mark);
        send_word(ddt_pkg::KIND_TICK, 1'b1, 1'b1, mark + 32'h8000_0000);
        send_word(ddt_pkg::KIND_TICK, 1'b0, 1'b1, mark + 32'h7fff_ffff);
        send_word(ddt_pkg::KIND_CLR_LEFT, 1'b0, 1'b0, 32'h0000_0000);
        send_word(ddt_pkg::KIND_TICK, 1'b1, 1'b0, 32'h0000_0000);
        send_word(ddt_pkg::KIND_CLR_RIGHT, 1'b1, 1'b1, 32'hffff_ffff);
    endtask

    initial begin
        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        in_if.valid        = 1'b0;
        in_if.kind         = ddt_pkg::KIND_TICK;
        in_if.left_sample  = 1'b0;
        in_if.right_sample = 1'b0;
        in_if.now_ms       = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings first, then the extremes and a few random settings.
        directed_words();
        random_words(200, ddt_pkg::INTERVAL_RESET / 16 + 1);
        run_phase(8'd1, 16'd1, 180);
        run_phase(8'd255, 16'd65535, 180);
        run_phase(8'd255, 16'd1, 180);
        run_phase(8'd1, 16'd30000, 180);
        run_phase(8'd7, 16'd13, 180);
        repeat (2) run_phase(8'($urandom_range(1, 255)), 16'($urandom_range(1, 400)), 180);

        // Final stretch runs at full rate on both sides.
        idling_allowed = 1'b0;
        gaps_on        = 1'b0;
        stalls_on      = 1'b0;
        run_phase(8'($urandom_range(1, 255)), 16'($urandom_range(1, 400)), 220);

        wait_for_readings();
        repeat (8) @(posedge i_clk);

        $display("summary: %0d words over %0d register settings, %0d clears",
                 sb.words, settings, sb.clears);
        $display("summary: %0d debounced pulses, %0d speed updates",
                 sb.pulses, sb.surveys);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

[sim.f]
sv/ddt_pkg.sv
sv/ddt_in_if.sv
sv/ddt_out_if.sv
sv/ddt_lane.sv
sv/ddt_scale_div.sv
sv/dual_debounced_tachometer_unit.sv
test/tb.sv
